@@ rtl/core/ftpm_pkg.sv @@
// Package for the fan tachometer and flow meter period meter: codes, constants, types.
package ftpm_pkg;

    // Opcodes of an input item
    localparam logic [1:0] OP_EDGE   = 2'd0;
    localparam logic [1:0] OP_WINDOW = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Field widths
    localparam int CH_FIELD_W = 3;
    localparam int STAMP_W    = 16;
    localparam int RATE_W     = 16;
    localparam int DEN_W      = 32;

    // Dividends: rpm and litres per hour scale factors
    localparam logic [27:0] RPM_NUMERATOR  = 28'd3750000;
    localparam logic [27:0] FLOW_NUMERATOR = 28'd225000000;
    localparam int          NUM_W          = 28;
    localparam int          CNT_W          = $clog2(NUM_W);

    localparam logic [15:0] IMPULSES_RESET = 16'd169;
    localparam logic [1:0]  EDGES_RESET    = 2'd2;
    localparam logic [15:0] RATE_SATURATE  = 16'hFFFF;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } fsm_state_t;

endpackage

@@ rtl/core/ftpm_if.sv @@
// Valid/ready channel interfaces for the period meter's input items and results.
interface ftpm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [2:0]  channel;
    logic [15:0] timestamp;

    modport source (output valid, output opcode, output channel, output timestamp,
                    input ready);
    modport sink   (input valid, input opcode, input channel, input timestamp,
                    output ready);
endinterface

interface ftpm_rate_if;
    logic        valid;
    logic        ready;
    logic [15:0] rate_value;
    logic        rate_valid;

    modport source (output valid, output rate_value, output rate_valid, input ready);
    modport sink   (input valid, input rate_value, input rate_valid, output ready);
endinterface

@@ rtl/core/fan_tach_flow_period_meter.sv @@
// Top level: five-channel tachometer / flow meter period meter with a serial divider.
//
//  channel    | dir | handshake       | payload
//  -----------+-----+-----------------+----------------------------------
//  item_in    | in  | valid / ready   | opcode, channel, timestamp
//  rate_out   | out | valid / ready   | rate_value, rate_valid
//  cfg        | in  | cfg_wr_en       | cfg_wr_data (impulses_per_liter)
//
// Edge, window-end and ignored items are registered and answered in the cycle after acceptance.
// A read of an enabled channel holds the input while it steps through the accept, a multiply
// for the divisor, the one-bit-per-cycle restoring divider over the 28-bit dividend, and a
// result load, which waits until the result register is free before the result is offered.
// Input ready is low while the divider runs, and while the result register is full and
// not being taken. Reset is asynchronous; no clearing pass is needed.
module fan_tach_flow_period_meter #(
    parameter int FAN_CHANNELS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    ftpm_item_if.sink           item_in,
    ftpm_rate_if.source         rate_out
);

    localparam int          NUM_CH   = FAN_CHANNELS + 1;
    localparam int          CH_W     = $clog2(NUM_CH);
    localparam logic [3:0]  NUM_CH_L = 4'(NUM_CH);
    localparam logic [3:0]  FLOW_CH  = 4'(FAN_CHANNELS);

    // Per-channel state
    logic [15:0] last_stamp_reg      [NUM_CH];
    logic [15:0] measured_period_reg [NUM_CH];
    logic [1:0]  edges_left_reg      [NUM_CH];
    logic [NUM_CH-1:0] enabled_reg;
    logic [15:0] impulses_reg;

    // Sequencer and datapath
    ftpm_pkg::fsm_state_t state_reg, state_next;
    logic [15:0]                  per_reg;
    logic                         is_flow_reg;
    logic [ftpm_pkg::DEN_W-1:0]   den_reg;
    logic [ftpm_pkg::NUM_W-1:0]   num_reg;
    logic [ftpm_pkg::DEN_W-1:0]   rem_reg;
    logic [15:0]                  quo_reg;
    logic [ftpm_pkg::CNT_W-1:0]   cnt_reg;

    // Result register
    logic        out_valid_reg;
    logic [15:0] out_value_reg;
    logic        out_flag_reg;

    logic              out_free;
    logic              in_ready;
    logic              accept;
    logic [3:0]        ch_ext;
    logic [CH_W-1:0]   ch_idx;
    logic              ch_ok;
    logic              read_go;
    logic              finish_load;

    logic [ftpm_pkg::DEN_W:0]   rem_shift;
    logic                       rem_ge;
    logic [ftpm_pkg::DEN_W:0]   rem_diff;

    // Channel decode
    assign ch_ext  = {1'b0, item_in.channel};
    assign ch_idx  = ch_ext[CH_W-1:0];
    assign ch_ok   = (ch_ext < NUM_CH_L);
    assign out_free = !out_valid_reg || rate_out.ready;
    assign accept   = item_in.valid && in_ready;
    assign read_go  = accept && (item_in.opcode == ftpm_pkg::OP_READ) && ch_ok
                      && enabled_reg[ch_idx];

    // Divider step: shift in the next dividend bit, subtract when it fits
    assign rem_shift = {rem_reg, num_reg[ftpm_pkg::NUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftpm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        finish_load = 1'b0;
        case (state_reg)
            ftpm_pkg::ST_IDLE:
            begin
                in_ready = out_free;
                if (read_go)
                begin
                    state_next = ftpm_pkg::ST_MUL;
                end
            end
            ftpm_pkg::ST_MUL:
            begin
                state_next = ftpm_pkg::ST_DIV;
            end
            ftpm_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ftpm_pkg::ST_FINISH;
                end
            end
            ftpm_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    finish_load = 1'b1;
                    state_next  = ftpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftpm_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            impulses_reg <= ftpm_pkg::IMPULSES_RESET;
        end
        else if (cfg_wr_en)
        begin
            impulses_reg <= cfg_wr_data;
        end
    end

    // Channel state: edges and window ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                last_stamp_reg[i]      <= '0;
                measured_period_reg[i] <= '0;
                edges_left_reg[i]      <= ftpm_pkg::EDGES_RESET;
            end
            enabled_reg <= '0;
        end
        else if (accept)
        begin
            case (item_in.opcode)
                ftpm_pkg::OP_EDGE:
                begin
                    if (ch_ok)
                    begin
                        if (edges_left_reg[ch_idx] < ftpm_pkg::EDGES_RESET)
                        begin
                            measured_period_reg[ch_idx] <=
                                item_in.timestamp - last_stamp_reg[ch_idx];
                        end
                        last_stamp_reg[ch_idx] <= item_in.timestamp;
                        if (edges_left_reg[ch_idx] != 2'd0)
                        begin
                            edges_left_reg[ch_idx] <= edges_left_reg[ch_idx] - 2'd1;
                        end
                    end
                end
                ftpm_pkg::OP_WINDOW:
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        enabled_reg[i]    <= (edges_left_reg[i] == 2'd0);
                        edges_left_reg[i] <= ftpm_pkg::EDGES_RESET;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Divider datapath: operand capture, divisor multiply, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ftpm_pkg::ST_IDLE:
            begin
                if (read_go)
                begin
                    per_reg     <= measured_period_reg[ch_idx];
                    is_flow_reg <= (ch_ext == FLOW_CH);
                end
            end
            ftpm_pkg::ST_MUL:
            begin
                if (is_flow_reg)
                begin
                    den_reg <= {16'd0, per_reg} * {16'd0, impulses_reg};
                    num_reg <= ftpm_pkg::FLOW_NUMERATOR;
                end
                else
                begin
                    den_reg <= {15'd0, per_reg, 1'b0};
                    num_reg <= ftpm_pkg::RPM_NUMERATOR;
                end
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= ftpm_pkg::CNT_W'(ftpm_pkg::NUM_W - 1);
            end
            ftpm_pkg::ST_DIV:
            begin
                rem_reg <= rem_ge ? rem_diff[ftpm_pkg::DEN_W-1:0]
                                  : rem_shift[ftpm_pkg::DEN_W-1:0];
                quo_reg <= {quo_reg[14:0], rem_ge};
                num_reg <= {num_reg[ftpm_pkg::NUM_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((accept && !read_go) || finish_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rate_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (accept && !read_go)
        begin
            out_value_reg <= '0;
            out_flag_reg  <= 1'b0;
        end
        else if (finish_load)
        begin
            out_value_reg <= (den_reg == '0) ? ftpm_pkg::RATE_SATURATE : quo_reg;
            out_flag_reg  <= 1'b1;
        end
    end

    assign item_in.ready       = in_ready;
    assign rate_out.valid      = out_valid_reg;
    assign rate_out.rate_value = out_value_reg;
    assign rate_out.rate_valid = out_flag_reg;

endmodule

@@ rtl/core/ftpm_checker.sv @@
// Port-level checker for the period meter, bound to the top level.
module ftpm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  in_opcode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_rate_value,
    input logic        out_rate_valid
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_rate_value) && $stable(out_rate_valid))
        else $error("result payload changed while stalled");

    // A result without the valid flag carries a zero rate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_rate_valid |-> out_rate_value == 16'd0)
        else $error("invalid rate is not zero");

    // Anything but a read is answered in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_opcode != ftpm_pkg::OP_READ |=> out_valid)
        else $error("non-read item not answered at once");

    // An item is only taken when the result register can take its answer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("item taken while a result waits");

endmodule

bind fan_tach_flow_period_meter ftpm_checker u_ftpm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (item_in.valid),
    .in_ready       (item_in.ready),
    .in_opcode      (item_in.opcode),
    .out_valid      (rate_out.valid),
    .out_ready      (rate_out.ready),
    .out_rate_value (rate_out.rate_value),
    .out_rate_valid (rate_out.rate_valid)
);
